// ===== hdl/uphc_pkg.sv =====
// Package for the UDP pseudo-header checksum block.
// Holds the port payload types, the queue entry types and the shared constants.
// No dependencies.
`timescale 1ns / 1ps

package uphc_pkg;

    // Codes of the action field.
    localparam logic ACTION_HEADER = 1'b0;
    localparam logic ACTION_DATA   = 1'b1;

    // Protocol number that the pseudo-header carries for UDP.
    localparam logic [15:0] UDP_PROTO = 16'd17;

    // All-ones word, the checksum value that the caller treats as failure.
    localparam logic [15:0] WORD_ALL_ONES = 16'hFFFF;

    // Widths of a partial sum of five 16-bit words and of the unfolded sum of one header (eighteen 16-bit words).
    localparam int PART_W  = 19;
    localparam int TOTAL_W = 21;

    // One input request.
    typedef struct packed {
        logic        action;
        logic        ip_version;
        logic [63:0] source_addr_high;
        logic [63:0] source_addr_low;
        logic [63:0] dest_addr_high;
        logic [63:0] dest_addr_low;
        logic [15:0] udp_length;
        logic [15:0] data_word;
        logic        single_byte;
        logic        last_word;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic [15:0] checksum;
        logic        reported_failure;
    } t_out_item;

    // Classified operation passed from the front end to the back end.
    // A header carries its folded pseudo-header sum, a data entry its masked word.
    typedef struct packed {
        logic        hdr;
        logic        last;
        logic [15:0] value;
    } t_mid;

endpackage

// ===== hdl/udp_pseudo_header_checksum_top.sv =====
// UDP checksum over the IPv4 or IPv6 pseudo-header and segment words.
// Throughput: one request per cycle while full is low; the back end folds one queued word into
// the sum each cycle while its queue holds entries and a last word finds room for its result.
// The front and back end are parted by a MID_DEPTH queue; results wait in an OUT_DEPTH queue.
// Synchronous reset clears the running sum and empties queues.
`timescale 1ns / 1ps

module udp_pseudo_header_checksum_top
    import uphc_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic      w_mid_push, w_mid_full, w_mid_pop, w_mid_empty;
    t_mid      w_mid_wdata, w_mid_rdata;
    logic      w_res_push, w_res_full;
    t_out_item w_res_wdata;

    // Front end: acceptance and header summing.
    uphc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .o_mid_push (w_mid_push),
        .o_mid_data (w_mid_wdata),
        .i_mid_full (w_mid_full)
    );

    // Queue of classified operations.
    uphc_fifo #(
        .t_data (t_mid),
        .DEPTH  (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_wdata),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_rdata),
        .o_empty (w_mid_empty)
    );

    // Back end: running sum and checksum.
    uphc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_data  (w_mid_rdata),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_wdata),
        .i_res_full  (w_res_full)
    );

    // Result queue towards the consumer.
    uphc_fifo #(
        .t_data (t_out_item),
        .DEPTH  (OUT_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_wdata),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// ===== hdl/uphc_fifo.sv =====
// Small first-word-fall-through queue with a type parameter for its entries.
// Used between front and back end and as the result queue. Depends on nothing.
`timescale 1ns / 1ps

module uphc_fifo #(
    parameter type t_data = logic,
    parameter int  DEPTH  = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_data              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    // Pointer and fill count updates, wrapping at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/uphc_front.sv =====
// Front end: accepts requests, sums the pseudo-header in two stages and
// classifies each request into a queue entry. Depends on uphc_pkg.
`timescale 1ns / 1ps

module uphc_front
    import uphc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_in_item i_item,
    output logic     full,
    output logic     o_mid_push,
    output t_mid     o_mid_data,
    input  logic     i_mid_full
);

    logic                r_s1_valid, n_s1_valid;
    logic                r_s1_hdr, r_s1_last;
    logic [PART_W-1:0]   r_s1_part [4];
    logic [PART_W-1:0]   n_s1_part [4];
    logic                r_s2_valid, n_s2_valid;
    logic                r_s2_hdr, r_s2_last;
    logic [TOTAL_W-1:0]  r_s2_total, n_s2_total;
    logic                w_advance, w_accept, w_v6;
    logic [15:0]         w_word;
    logic [63:0]         w_src_hi, w_src_lo, w_dst_hi, w_dst_lo;
    logic [16:0]         w_fold1;
    logic [15:0]         w_fold2;

    // Sum of the four 16-bit words of a 64-bit quantity.
    function automatic logic [PART_W-1:0] sum_quad(input logic [63:0] v);
        return PART_W'(v[15:0]) + PART_W'(v[31:16]) + PART_W'(v[47:32])
             + PART_W'(v[63:48]);
    endfunction

    // The whole pipeline moves when its last stage is empty or can drain.
    assign w_advance = !r_s2_valid || !i_mid_full;
    assign full      = !w_advance;
    assign w_accept  = push && w_advance;

    // IPv4 keeps only the low 32 bits of each address.
    assign w_v6     = i_item.ip_version;
    assign w_src_hi = i_item.source_addr_high & {64{w_v6}};
    assign w_dst_hi = i_item.dest_addr_high & {64{w_v6}};
    assign w_src_lo = i_item.source_addr_low & {{32{w_v6}}, 32'hFFFF_FFFF};
    assign w_dst_lo = i_item.dest_addr_low & {{32{w_v6}}, 32'hFFFF_FFFF};

    // An odd tail byte is padded with a zero low byte.
    assign w_word = i_item.single_byte ? {i_item.data_word[15:8], 8'h00}
                                       : i_item.data_word;

    // Stage one: four partial sums; a data word travels alone in the first.
    always_comb begin
        n_s1_valid = w_accept;
        if (i_item.action == ACTION_DATA) begin
            n_s1_part[0] = PART_W'(w_word);
            n_s1_part[1] = '0;
            n_s1_part[2] = '0;
            n_s1_part[3] = '0;
        end else begin
            n_s1_part[0] = sum_quad(w_src_hi) + PART_W'(UDP_PROTO);
            n_s1_part[1] = sum_quad(w_src_lo) + PART_W'(i_item.udp_length);
            n_s1_part[2] = sum_quad(w_dst_hi);
            n_s1_part[3] = sum_quad(w_dst_lo);
        end
    end

    // Stage two: total of the partial sums.
    always_comb begin
        n_s2_valid = r_s1_valid;
        n_s2_total = TOTAL_W'(r_s1_part[0]) + TOTAL_W'(r_s1_part[1])
                   + TOTAL_W'(r_s1_part[2]) + TOTAL_W'(r_s1_part[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_hdr   <= (i_item.action == ACTION_HEADER);
            r_s1_last  <= i_item.last_word;
            r_s1_part  <= n_s1_part;
            r_s2_hdr   <= r_s1_hdr;
            r_s2_last  <= r_s1_last;
            r_s2_total <= n_s2_total;
        end
    end

    // End-around carry fold of the total down to 16 bits; zero stays zero.
    assign w_fold1 = {1'b0, r_s2_total[15:0]} + 17'(r_s2_total[TOTAL_W-1:16]);
    assign w_fold2 = w_fold1[15:0] + 16'(w_fold1[16]);

    // Classified entry towards the back end.
    always_comb begin
        o_mid_push       = r_s2_valid && !i_mid_full;
        o_mid_data.hdr   = r_s2_hdr;
        o_mid_data.last  = r_s2_last;
        o_mid_data.value = w_fold2;
    end

endmodule

// ===== hdl/uphc_back.sv =====
// Back end: holds the running one's complement sum, applies queued entries
// in order and emits the checksum on the last word. Depends on uphc_pkg.
`timescale 1ns / 1ps

module uphc_back
    import uphc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mid      i_mid_data,
    input  logic      i_mid_empty,
    output logic      o_mid_pop,
    output logic      o_res_push,
    output t_out_item o_res_data,
    input  logic      i_res_full
);

    logic [15:0] r_sum, n_sum;
    logic [16:0] w_add;
    logic [15:0] w_add_fold;
    logic [15:0] w_chk;
    logic        w_needs_room;

    // One's complement add of the queued word to the running sum.
    assign w_add      = {1'b0, r_sum} + {1'b0, i_mid_data.value};
    assign w_add_fold = w_add[15:0] + 16'(w_add[16]);
    assign w_chk      = ~w_add_fold;

    // Only a last data word needs space in the result queue.
    assign w_needs_room = !i_mid_data.hdr && i_mid_data.last;

    always_comb begin
        o_mid_pop  = !i_mid_empty && (!w_needs_room || !i_res_full);
        o_res_push = o_mid_pop && w_needs_room;
        o_res_data.checksum         = w_chk;
        o_res_data.reported_failure = (w_chk == WORD_ALL_ONES);
    end

    // A header restarts the sum, a data word adds to it.
    always_comb begin
        n_sum = r_sum;
        if (o_mid_pop) begin
            n_sum = i_mid_data.hdr ? i_mid_data.value : w_add_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

endmodule

// ===== hdl/uphc_checker.sv =====
// Port-level checks for the UDP checksum block, bound to the top level.
// Depends on uphc_pkg.
`timescale 1ns / 1ps

module uphc_checker
    import uphc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      push,
    input t_in_item  i_item,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    // No result can come out sooner than the pipeline depth after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty ##1 empty ##1 empty)
        else $error("result shown too soon after reset");

    // The front end is ready straight after reset.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !full)
        else $error("full raised straight after reset");

    // The failure flag always agrees with the checksum shown.
    a_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.reported_failure == (o_result.checksum == WORD_ALL_ONES)))
        else $error("failure flag disagrees with checksum");

    // A waiting result is neither lost nor changed.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result lost or changed");

endmodule

bind udp_pseudo_header_checksum_top uphc_checker u_checker (.*);

// ===== tb/testbench.sv =====
// Testbench for the UDP pseudo-header checksum block.
// Sends headers and segment words through the request queue and checks every checksum.
// Depends on uphc_pkg and udp_pseudo_header_checksum_top.
`timescale 1ns / 1ps

module testbench;
    import uphc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CALM_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 1000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    t_in_item  i_item  = '0;
    logic      pop     = 1'b0;
    logic      full;
    logic      empty;
    t_out_item o_result;

    // Requests waiting to be sent, and checksums still owed by the block.
    t_in_item    pending_reqs[$];
    t_out_item   checksum_due[$];
    logic [15:0] seg_sum     = '0;
    int          mismatches  = 0;
    int          send_gap    = 0;
    int          recv_gap    = 0;
    int          idle_cycles = 0;
    bit          calm_tail   = 1'b0;

    udp_pseudo_header_checksum_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // One's complement addition of a 16-bit word, folded back to 16 bits.
    function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Adds the four words of a 64-bit value, most significant word first.
    function automatic logic [15:0] add_quad(input logic [15:0] acc, input logic [63:0] v);
        logic [15:0] a;
        a = acc;
        for (int i = 3; i >= 0; i--) begin
            a = ones_add(a, v[16*i +: 16]);
        end
        return a;
    endfunction

    // Pseudo-header sum that a header request seeds the running sum with.
    function automatic logic [15:0] pseudo_header_sum(input t_in_item r);
        logic [15:0] a;
        a = '0;
        if (r.ip_version) begin
            a = add_quad(a, r.source_addr_high);
            a = add_quad(a, r.source_addr_low);
            a = add_quad(a, r.dest_addr_high);
            a = add_quad(a, r.dest_addr_low);
        end else begin
            // IPv4 takes only the low 32 bits of each address.
            a = add_quad(a, {32'd0, r.source_addr_low[31:0]});
            a = add_quad(a, {32'd0, r.dest_addr_low[31:0]});
        end
        a = ones_add(a, UDP_PROTO);
        a = ones_add(a, r.udp_length);
        return a;
    endfunction

    // Updates the running sum for an accepted request and queues any checksum it yields.
    task automatic track_request(input t_in_item r);
        logic [15:0] w;
        t_out_item   res;
        if (r.action == ACTION_HEADER) begin
            seg_sum = pseudo_header_sum(r);
        end else begin
            w = r.data_word;
            if (r.single_byte) begin
                w[7:0] = 8'h00;
            end
            seg_sum = ones_add(seg_sum, w);
            if (r.last_word) begin
                res.checksum         = ~seg_sum;
                res.reported_failure = (res.checksum == WORD_ALL_ONES);
                checksum_due.push_back(res);
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Compares one result with the oldest checksum still owed.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (checksum_due.size() == 0) begin
            flag_mismatch("unexpected result", got.checksum, 16'h0000);
        end else begin
            want = checksum_due.pop_front();
            if (got.checksum !== want.checksum) begin
                flag_mismatch("checksum", got.checksum, want.checksum);
            end
            if (got.reported_failure !== want.reported_failure) begin
                flag_mismatch("reported_failure", {15'd0, got.reported_failure},
                              {15'd0, want.reported_failure});
            end
        end
    endtask

    // A request with every field random; callers overwrite the fields that matter.
    function automatic t_in_item rand_req();
        t_in_item r;
        r.action           = 1'($urandom_range(0, 1));
        r.ip_version       = 1'($urandom_range(0, 1));
        r.source_addr_high = {$urandom, $urandom};
        r.source_addr_low  = {$urandom, $urandom};
        r.dest_addr_high   = {$urandom, $urandom};
        r.dest_addr_low    = {$urandom, $urandom};
        r.udp_length       = 16'($urandom_range(0, 16'hFFFF));
        r.data_word        = 16'($urandom_range(0, 16'hFFFF));
        r.single_byte      = 1'($urandom_range(0, 1));
        r.last_word        = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_in_item header_req(input logic v6, input logic [63:0] sh,
                                            input logic [63:0] sl, input logic [63:0] dh,
                                            input logic [63:0] dl, input logic [15:0] len);
        t_in_item r;
        r                  = rand_req();
        r.action           = ACTION_HEADER;
        r.ip_version       = v6;
        r.source_addr_high = sh;
        r.source_addr_low  = sl;
        r.dest_addr_high   = dh;
        r.dest_addr_low    = dl;
        r.udp_length       = len;
        return r;
    endfunction

    function automatic t_in_item data_req(input logic [15:0] word, input logic single,
                                          input logic last);
        t_in_item r;
        r             = rand_req();
        r.action      = ACTION_DATA;
        r.data_word   = word;
        r.single_byte = single;
        r.last_word   = last;
        return r;
    endfunction

    // Clock and the single reset at the start of the run.
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: presents queued requests, with random idle bursts until the tail of the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                track_request(i_item);
            end
            calm_tail <= (pending_reqs.size() < CALM_ITEMS);
            if (!push || !full) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    push     <= 1'b0;
                end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(0, 8);
                    push     <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    i_item <= pending_reqs.pop_front();
                    push   <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results with random stall bursts and checks each one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_result(o_result);
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                pop      <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 8);
                pop      <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus: directed corner cases, then random packets, then the final verdict.
    initial begin
        int       first_random;
        int       kind;
        int       seg_bytes;
        int       n_words;
        int       n_extra;
        logic     v6;
        logic     wide_v4;
        logic     is_last;
        t_in_item r;

        // From reset the sum is zero, so a zero word gives the all-ones failure value.
        pending_reqs.push_back(data_req(16'h0000, 1'b0, 1'b1));
        // Words after the last one keep adding to the same sum.
        pending_reqs.push_back(data_req(16'hFFFF, 1'b0, 1'b1));
        pending_reqs.push_back(data_req(16'hFFFF, 1'b1, 1'b1));
        // IPv4 header with every ignored address bit set.
        pending_reqs.push_back(header_req(1'b0, '1, '1, '1, '1, 16'hFFFF));
        pending_reqs.push_back(data_req(16'h1234, 1'b1, 1'b0));
        pending_reqs.push_back(data_req(16'hABCD, 1'b0, 1'b1));
        pending_reqs.push_back(data_req(16'h0001, 1'b0, 1'b1));
        // IPv6 extremes.
        pending_reqs.push_back(header_req(1'b1, '1, '1, '1, '1, 16'h0000));
        pending_reqs.push_back(data_req(16'hFFFF, 1'b0, 1'b1));
        pending_reqs.push_back(header_req(1'b1, '0, '0, '0, '0, 16'h0000));
        pending_reqs.push_back(data_req(16'h0000, 1'b0, 1'b1));
        // A small, well-formed IPv4 datagram with an odd tail byte.
        pending_reqs.push_back(header_req(1'b0, 64'hFFFF_FFFF_0000_0000,
                                          64'hFFFF_FFFF_C0A8_0001, '1,
                                          64'h0000_0000_C0A8_00C7, 16'd11));
        pending_reqs.push_back(data_req(16'h04D2, 1'b0, 1'b0));
        pending_reqs.push_back(data_req(16'h0035, 1'b0, 1'b0));
        pending_reqs.push_back(data_req(16'h000B, 1'b0, 1'b0));
        pending_reqs.push_back(data_req(16'h0000, 1'b0, 1'b0));
        pending_reqs.push_back(data_req(16'h4869, 1'b0, 1'b0));
        pending_reqs.push_back(data_req(16'h21FF, 1'b1, 1'b1));

        // Random part: mostly whole packets, some noise and broken sequences.
        first_random = pending_reqs.size();
        while (pending_reqs.size() - first_random < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // Noise: anything at all.
                repeat ($urandom_range(1, 4)) pending_reqs.push_back(rand_req());
            end else if (kind == 1) begin
                // Data with no header in front, the end flag random.
                repeat ($urandom_range(1, 5)) begin
                    r        = rand_req();
                    r.action = ACTION_DATA;
                    pending_reqs.push_back(r);
                end
            end else begin
                v6        = 1'($urandom_range(0, 1));
                wide_v4   = 1'($urandom_range(0, 1));
                seg_bytes = 8 + (($urandom_range(0, 19) == 0) ? $urandom_range(0, 200)
                                                               : $urandom_range(0, 16));
                n_words   = (seg_bytes + 1) / 2;
                r = header_req(v6, {$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom},
                               16'(seg_bytes));
                if (!v6 && !wide_v4) begin
                    r.source_addr_high      = '0;
                    r.dest_addr_high        = '0;
                    r.source_addr_low[63:32] = '0;
                    r.dest_addr_low[63:32]   = '0;
                end
                if ($urandom_range(0, 7) == 0) begin
                    r.udp_length = 16'($urandom_range(0, 16'hFFFF));
                end
                pending_reqs.push_back(r);
                for (int i = 0; i < n_words; i++) begin
                    is_last = (i == n_words - 1);
                    pending_reqs.push_back(data_req(16'($urandom_range(0, 16'hFFFF)),
                                                    is_last && (seg_bytes % 2 == 1), is_last));
                end
                // Occasionally words trail the last one, ending in a second result.
                if ($urandom_range(0, 9) == 0) begin
                    n_extra = $urandom_range(1, 3);
                    for (int i = 0; i < n_extra; i++) begin
                        pending_reqs.push_back(data_req(16'($urandom_range(0, 16'hFFFF)),
                                                        1'($urandom_range(0, 1)),
                                                        i == n_extra - 1));
                    end
                end
            end
        end

        // Wait for every request to go in and every checksum to come out.
        wait (i_rst_n);
        while (pending_reqs.size() != 0 || push) @(posedge i_clk);
        while (checksum_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
